// ===== rtl/rebb_pkg.sv =====
// ----------------------------------------------------------------------------
// rebb_pkg
// Types, widths and constants shared by the ellipse bounding box pipeline.
// ----------------------------------------------------------------------------
package rebb_pkg;

    localparam int DEF_CORDIC_STEPS = 16;
    localparam int MAX_CORDIC_STEPS = 24;

    localparam int CW    = 34;
    localparam int PW    = 25;
    localparam int SQ_W  = 52;
    localparam int SQ_STEPS = 26;
    localparam int RW    = 26;

    localparam logic [15:0] AXIS_SCALE_RST = 16'd4096;

    localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CW-1:0] PI_Q30       = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30  = 34'sd1686629713;

    localparam logic [31:0] ATAN_TAB [0:MAX_CORDIC_STEPS-1] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128
    };

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [31:0]        a;
        logic [31:0]        b;
    } side_t;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
    } ctr_t;

endpackage

// ===== rtl/rebb_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// rebb_cordic_cell
// One rotation-mode CORDIC iteration with its pipeline register.
// ----------------------------------------------------------------------------
module rebb_cordic_cell
    import rebb_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] in_x,
    input  logic signed [CW-1:0] in_y,
    input  logic signed [CW-1:0] in_z,
    input  side_t                in_side,
    output logic                 out_valid,
    output logic signed [CW-1:0] out_x,
    output logic signed [CW-1:0] out_y,
    output logic signed [CW-1:0] out_z,
    output side_t                out_side
);

    localparam logic signed [CW-1:0] ATAN = CW'(ATAN_TAB[STEP]);

    logic                 valid_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] x_next, y_next, z_next;
    logic signed [CW-1:0] dx, dy;
    side_t                side_reg;

    always_comb begin
        dx = in_y >>> STEP;
        dy = in_x >>> STEP;
        if (!in_z[CW-1]) begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ATAN;
        end else begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/rebb_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rebb_sqrt_cell
// One digit of two parallel integer square roots with its pipeline register.
// ----------------------------------------------------------------------------
module rebb_sqrt_cell
    import rebb_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [SQ_W-1:0] in_vx,
    input  logic [SQ_W-1:0] in_rx,
    input  logic [SQ_W-1:0] in_vy,
    input  logic [SQ_W-1:0] in_ry,
    input  ctr_t            in_ctr,
    output logic            out_valid,
    output logic [SQ_W-1:0] out_vx,
    output logic [SQ_W-1:0] out_rx,
    output logic [SQ_W-1:0] out_vy,
    output logic [SQ_W-1:0] out_ry,
    output ctr_t            out_ctr
);

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - STEP));

    logic            valid_reg;
    logic [SQ_W-1:0] vx_reg, rx_reg, vy_reg, ry_reg;
    logic [SQ_W-1:0] vx_next, rx_next, vy_next, ry_next;
    logic [SQ_W-1:0] tx, ty;
    ctr_t            ctr_reg;

    always_comb begin
        tx = in_rx + BIT;
        ty = in_ry + BIT;
        if (in_vx >= tx) begin
            vx_next = in_vx - tx;
            rx_next = (in_rx >> 1) + BIT;
        end else begin
            vx_next = in_vx;
            rx_next = in_rx >> 1;
        end
        if (in_vy >= ty) begin
            vy_next = in_vy - ty;
            ry_next = (in_ry >> 1) + BIT;
        end else begin
            vy_next = in_vy;
            ry_next = in_ry >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vx_reg  <= vx_next;
            rx_reg  <= rx_next;
            vy_reg  <= vy_next;
            ry_reg  <= ry_next;
            ctr_reg <= in_ctr;
        end
    end

    assign out_valid = valid_reg;
    assign out_vx    = vx_reg;
    assign out_rx    = rx_reg;
    assign out_vy    = vy_reg;
    assign out_ry    = ry_reg;
    assign out_ctr   = ctr_reg;

endmodule

// ===== rtl/rotated_ellipse_bounding_box_top.sv =====
// ----------------------------------------------------------------------------
// rotated_ellipse_bounding_box_top
// Axis-aligned bounding box of a scaled, rotated ellipse.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the skid stage is empty; the
// CORDIC and square root cell chains are fully pipelined, and a one-entry
// skid stage absorbs a stall, and while full it holds the whole pipeline.
// Reset clears all valid bits and the skid stage and sets axis_scale to 1.0.
module rotated_ellipse_bounding_box_top
    import rebb_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_center_x,
    input  logic signed [15:0] s_center_y,
    input  logic [15:0]        s_semi_major,
    input  logic [15:0]        s_semi_minor,
    input  logic signed [15:0] s_angle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [18:0] m_rect_left,
    output logic signed [18:0] m_rect_top,
    output logic [17:0]        m_rect_width,
    output logic [17:0]        m_rect_height
);

    logic [15:0] scale_reg;
    logic        adv;
    logic        skid_full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= AXIS_SCALE_RST;
        end else if (cfg_valid) begin
            scale_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign adv       = !skid_full_reg;
    assign s_ready   = adv;

    // input stage
    logic                 in_valid_reg;
    side_t                in_side_reg;
    logic signed [CW-1:0] in_z_reg;
    logic signed [CW-1:0] z_raw, z_next;

    always_comb begin
        z_raw = CW'(s_angle) <<< 17;
        if (z_raw > HALF_PI_Q30) begin
            z_next = z_raw - PI_Q30;
        end else if (z_raw < -HALF_PI_Q30) begin
            z_next = z_raw + PI_Q30;
        end else begin
            z_next = z_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_side_reg.cx <= s_center_x;
            in_side_reg.cy <= s_center_y;
            in_side_reg.a  <= 32'(s_semi_major) * 32'(scale_reg);
            in_side_reg.b  <= 32'(s_semi_minor) * 32'(scale_reg);
            in_z_reg       <= z_next;
        end
    end

    // CORDIC chain
    logic                 cv [0:CORDIC_STEPS];
    logic signed [CW-1:0] cx_w [0:CORDIC_STEPS];
    logic signed [CW-1:0] cy_w [0:CORDIC_STEPS];
    logic signed [CW-1:0] cz_w [0:CORDIC_STEPS];
    side_t                cs_w [0:CORDIC_STEPS];

    assign cv[0]   = in_valid_reg;
    assign cx_w[0] = INV_GAIN_Q30;
    assign cy_w[0] = '0;
    assign cz_w[0] = in_z_reg;
    assign cs_w[0] = in_side_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        rebb_cordic_cell #(.STEP(i)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (cv[i]),
            .in_x      (cx_w[i]),
            .in_y      (cy_w[i]),
            .in_z      (cz_w[i]),
            .in_side   (cs_w[i]),
            .out_valid (cv[i+1]),
            .out_x     (cx_w[i+1]),
            .out_y     (cy_w[i+1]),
            .out_z     (cz_w[i+1]),
            .out_side  (cs_w[i+1])
        );
    end

    // products
    logic [31:0]  cmag, smag;
    logic [63:0]  ac_full, as_full, bc_full, bs_full;
    logic         mul_valid_reg;
    logic [PW-1:0] ac_reg, as_reg, bc_reg, bs_reg;
    ctr_t         mul_ctr_reg;

    always_comb begin
        cmag    = 32'(cx_w[CORDIC_STEPS][CW-1] ? -cx_w[CORDIC_STEPS] : cx_w[CORDIC_STEPS]);
        smag    = 32'(cy_w[CORDIC_STEPS][CW-1] ? -cy_w[CORDIC_STEPS] : cy_w[CORDIC_STEPS]);
        ac_full = 64'(cs_w[CORDIC_STEPS].a) * 64'(cmag);
        as_full = 64'(cs_w[CORDIC_STEPS].a) * 64'(smag);
        bc_full = 64'(cs_w[CORDIC_STEPS].b) * 64'(cmag);
        bs_full = 64'(cs_w[CORDIC_STEPS].b) * 64'(smag);
    end

    // squares
    logic            sq_valid_reg;
    logic [2*PW-1:0] acq_reg, asq_reg, bcq_reg, bsq_reg;
    ctr_t            sq_ctr_reg;

    // sums
    logic            sum_valid_reg;
    logic [SQ_W-1:0] vx_reg, vy_reg;
    ctr_t            sum_ctr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else if (adv) begin
            mul_valid_reg <= cv[CORDIC_STEPS];
            sq_valid_reg  <= mul_valid_reg;
            sum_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ac_reg         <= ac_full[38+PW-1:38];
            as_reg         <= as_full[38+PW-1:38];
            bc_reg         <= bc_full[38+PW-1:38];
            bs_reg         <= bs_full[38+PW-1:38];
            mul_ctr_reg.cx <= cs_w[CORDIC_STEPS].cx;
            mul_ctr_reg.cy <= cs_w[CORDIC_STEPS].cy;
            acq_reg        <= (2*PW)'(ac_reg) * (2*PW)'(ac_reg);
            asq_reg        <= (2*PW)'(as_reg) * (2*PW)'(as_reg);
            bcq_reg        <= (2*PW)'(bc_reg) * (2*PW)'(bc_reg);
            bsq_reg        <= (2*PW)'(bs_reg) * (2*PW)'(bs_reg);
            sq_ctr_reg     <= mul_ctr_reg;
            vx_reg         <= SQ_W'(acq_reg) + SQ_W'(bsq_reg);
            vy_reg         <= SQ_W'(asq_reg) + SQ_W'(bcq_reg);
            sum_ctr_reg    <= sq_ctr_reg;
        end
    end

    // square root chain
    logic            qv [0:SQ_STEPS];
    logic [SQ_W-1:0] qvx [0:SQ_STEPS];
    logic [SQ_W-1:0] qrx [0:SQ_STEPS];
    logic [SQ_W-1:0] qvy [0:SQ_STEPS];
    logic [SQ_W-1:0] qry [0:SQ_STEPS];
    ctr_t            qc  [0:SQ_STEPS];

    assign qv[0]  = sum_valid_reg;
    assign qvx[0] = vx_reg;
    assign qrx[0] = '0;
    assign qvy[0] = vy_reg;
    assign qry[0] = '0;
    assign qc[0]  = sum_ctr_reg;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        rebb_sqrt_cell #(.STEP(k)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (qv[k]),
            .in_vx     (qvx[k]),
            .in_rx     (qrx[k]),
            .in_vy     (qvy[k]),
            .in_ry     (qry[k]),
            .in_ctr    (qc[k]),
            .out_valid (qv[k+1]),
            .out_vx    (qvx[k+1]),
            .out_rx    (qrx[k+1]),
            .out_vy    (qvy[k+1]),
            .out_ry    (qry[k+1]),
            .out_ctr   (qc[k+1])
        );
    end

    // result formatting
    logic [RW-1:0]      rx, ry;
    logic signed [27:0] dxc, dyc;
    logic signed [19:0] qx, qy;
    logic signed [18:0] left_w, top_w;
    logic [17:0]        width_w, height_w;
    logic               tail_valid;

    assign rx         = qrx[SQ_STEPS][RW-1:0];
    assign ry         = qry[SQ_STEPS][RW-1:0];
    assign tail_valid = qv[SQ_STEPS];

    always_comb begin
        dxc = (28'(qc[SQ_STEPS].cx) <<< 4) - $signed({2'b00, rx});
        dyc = (28'(qc[SQ_STEPS].cy) <<< 4) - $signed({2'b00, ry});
        qx  = 20'((dxc + (dxc[27] ? 28'sd255 : 28'sd0)) >>> 8);
        qy  = 20'((dyc + (dyc[27] ? 28'sd255 : 28'sd0)) >>> 8);
        if (qx > 20'sd262143) begin
            left_w = 19'sd262143;
        end else if (qx < -20'sd262144) begin
            left_w = -19'sd262144;
        end else begin
            left_w = qx[18:0];
        end
        if (qy > 20'sd262143) begin
            top_w = 19'sd262143;
        end else if (qy < -20'sd262144) begin
            top_w = -19'sd262144;
        end else begin
            top_w = qy[18:0];
        end
        width_w  = rx[RW-1] ? 18'h3FFFF : rx[RW-2:7];
        height_w = ry[RW-1] ? 18'h3FFFF : ry[RW-2:7];
    end

    // output register and skid stage
    logic               m_valid_reg;
    logic signed [18:0] left_reg, top_reg, skid_left_reg, skid_top_reg;
    logic [17:0]        width_reg, height_reg, skid_width_reg, skid_height_reg;
    logic               out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (out_free) begin
                m_valid_reg   <= 1'b1;
                skid_full_reg <= 1'b0;
            end
        end else if (tail_valid) begin
            if (out_free) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_full_reg <= 1'b1;
            end
        end else if (out_free) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_full_reg) begin
            if (out_free) begin
                left_reg   <= skid_left_reg;
                top_reg    <= skid_top_reg;
                width_reg  <= skid_width_reg;
                height_reg <= skid_height_reg;
            end
        end else if (tail_valid) begin
            if (out_free) begin
                left_reg   <= left_w;
                top_reg    <= top_w;
                width_reg  <= width_w;
                height_reg <= height_w;
            end else begin
                skid_left_reg   <= left_w;
                skid_top_reg    <= top_w;
                skid_width_reg  <= width_w;
                skid_height_reg <= height_w;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_rect_left   = left_reg;
    assign m_rect_top    = top_reg;
    assign m_rect_width  = width_reg;
    assign m_rect_height = height_reg;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> m_valid_reg)
        else $error("skid stage full while output register empty");

    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (!skid_full_reg && tail_valid && m_valid_reg && !m_ready) |=> skid_full_reg)
        else $error("stalled result not captured in skid stage");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_full_reg && m_ready) |=> (!skid_full_reg && m_valid_reg))
        else $error("skid stage did not drain into output register");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && !skid_full_reg))
        else $error("output not cleared by reset");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the rotated ellipse bounding box pipeline. Ellipses go in on
// the valid/ready input channel and boxes come out on the result channel.
// A scoreboard predicts each box with a CORDIC and integer square root model
// in the same fixed point and compares the boxes in order. The scale register
// is changed between phases, and in some phases both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import rebb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [15:0]        major;
        logic [15:0]        minor;
        logic signed [15:0] angle;
    } ellipse_t;

    typedef struct {
        logic signed [18:0] left;
        logic signed [18:0] top;
        logic [17:0]        width;
        logic [17:0]        height;
    } box_t;

    class box_scoreboard;
        logic [15:0] scale = AXIS_SCALE_RST;
        box_t        pending_boxes[$];
        int          errors = 0;

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function logic [18:0] edge_pos(logic signed [15:0] c, longint unsigned r);
            longint v;
            v = (longint'(c) * 16 - longint'(r)) / 256;
            if (v > 262143) v = 262143;
            if (v < -262144) v = -262144;
            return v[18:0];
        endfunction

        function logic [17:0] span(longint unsigned r);
            longint unsigned v;
            v = (2 * r) >> 8;
            return (v > 262143) ? 18'h3FFFF : v[17:0];
        endfunction

        function box_t bound_ellipse(ellipse_t e);
            longint unsigned a, b, c, s, ac, as_, bc, bs, rx, ry;
            longint x, y, z, dx, dy;
            box_t r;
            a = longint'(e.major) * scale;
            b = longint'(e.minor) * scale;
            z = longint'(e.angle) * 131072;
            x = longint'(INV_GAIN_Q30);
            y = 0;
            if (z > longint'(HALF_PI_Q30)) z -= longint'(PI_Q30);
            else if (z < -longint'(HALF_PI_Q30)) z += longint'(PI_Q30);
            for (int i = 0; i < DEF_CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
                end else begin
                    x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
                end
            end
            c = (x < 0) ? -x : x;
            s = (y < 0) ? -y : y;
            ac  = (a * c) >> 38;
            as_ = (a * s) >> 38;
            bc  = (b * c) >> 38;
            bs  = (b * s) >> 38;
            rx = int_sqrt(ac * ac + bs * bs);
            ry = int_sqrt(as_ * as_ + bc * bc);
            r.left   = edge_pos(e.cx, rx);
            r.top    = edge_pos(e.cy, ry);
            r.width  = span(rx);
            r.height = span(ry);
            return r;
        endfunction

        function void report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endfunction

        function void note_ellipse(ellipse_t e);
            pending_boxes.insert(pending_boxes.size(), bound_ellipse(e));
        endfunction

        function void check_box(box_t got);
            box_t want;
            if (pending_boxes.size() == 0) begin
                report("box with none pending");
                return;
            end
            want = pending_boxes.pop_front();
            if (got.left !== want.left)
                report($sformatf("left %0d want %0d", got.left, want.left));
            if (got.top !== want.top)
                report($sformatf("top %0d want %0d", got.top, want.top));
            if (got.width !== want.width)
                report($sformatf("width %0d want %0d", got.width, want.width));
            if (got.height !== want.height)
                report($sformatf("height %0d want %0d", got.height, want.height));
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_center_x = '0;
    logic signed [15:0] s_center_y = '0;
    logic [15:0]        s_semi_major = '0;
    logic [15:0]        s_semi_minor = '0;
    logic signed [15:0] s_angle = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [18:0] m_rect_left;
    logic signed [18:0] m_rect_top;
    logic [17:0]        m_rect_width;
    logic [17:0]        m_rect_height;

    box_scoreboard sb = new();
    int src_idle = 0;
    int dst_idle = 0;

    rotated_ellipse_bounding_box_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_center_x(s_center_x), .s_center_y(s_center_y),
        .s_semi_major(s_semi_major), .s_semi_minor(s_semi_minor), .s_angle(s_angle),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_rect_left(m_rect_left), .m_rect_top(m_rect_top),
        .m_rect_width(m_rect_width), .m_rect_height(m_rect_height)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        box_t got;
        if (aresetn && m_valid && m_ready) begin
            got.left   = m_rect_left;
            got.top    = m_rect_top;
            got.width  = m_rect_width;
            got.height = m_rect_height;
            sb.check_box(got);
        end
        m_ready <= ($urandom_range(0, 99) >= dst_idle);
    end

    task automatic send_ellipse(ellipse_t e);
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_center_x   <= e.cx;
        s_center_y   <= e.cy;
        s_semi_major <= e.major;
        s_semi_minor <= e.minor;
        s_angle      <= e.angle;
        do @(posedge aclk); while (!s_ready);
        sb.note_ellipse(e);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_boxes.size() != 0) @(posedge aclk);
        repeat (DEF_CORDIC_STEPS + 40) @(posedge aclk);
    endtask

    task automatic write_scale(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.scale = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic ellipse_t mk(int cx, int cy, int ma, int mi, int an);
        ellipse_t e;
        e.cx = 16'(cx); e.cy = 16'(cy); e.major = 16'(ma); e.minor = 16'(mi);
        e.angle = 16'(an);
        return e;
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 255));
            1: return 16'($urandom_range(0, 4095));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic ellipse_t rand_ellipse();
        return mk($urandom, $urandom, int'(rand_axis()), int'(rand_axis()),
                  int'($urandom_range(0, 51472)) - 25736);
    endfunction

    initial begin
        logic [15:0] scales[4];
        int idle_src[4], idle_dst[4];
        scales   = '{16'd65535, 16'd0, 16'd1, 16'd4096};
        idle_src = '{38, 63, 0, 38};
        idle_dst = '{63, 38, 0, 63};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_ellipse(mk(0, 0, 0, 0, 0));
        send_ellipse(mk(32767, 32767, 65535, 65535, 0));
        send_ellipse(mk(-32768, -32768, 65535, 0, 25736));
        send_ellipse(mk(-32768, 32767, 0, 65535, -25736));
        send_ellipse(mk(100, -100, 65535, 1, 12868));
        send_ellipse(mk(-100, 100, 65535, 1, 12869));
        send_ellipse(mk(-5, 5, 1000, 20, -12868));
        send_ellipse(mk(5, -5, 1000, 20, -12869));
        send_ellipse(mk(-17, -31, 800, 800, 6434));
        send_ellipse(mk(4660, -4660, 160, 48, -6434));
        send_ellipse(mk(32767, -32768, 65535, 65535, 25000));
        send_ellipse(mk(-1, -15, 0, 3, 1));
        send_ellipse(mk(1, 15, 3, 0, -1));
        drain();

        for (int p = 0; p < 4; p++) begin
            write_scale(p == 3 ? 16'($urandom) : scales[p]);
            src_idle = idle_src[p < 3 ? p : 2];
            dst_idle = idle_dst[p < 3 ? p : 2];
            for (int n = 0; n < 220; n++) send_ellipse(rand_ellipse());
            drain();
        end
        write_scale(AXIS_SCALE_RST);
        for (int n = 0; n < 20; n++) send_ellipse(rand_ellipse());
        drain();

        if (sb.errors == 0 && sb.pending_boxes.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        #4ms;
        $display("tb_top: done, errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/rebb_pkg.sv
rtl/rebb_cordic_cell.sv
rtl/rebb_sqrt_cell.sv
rtl/rotated_ellipse_bounding_box_top.sv
sim/tb_top.sv
